>>> design/wis_pkg.sv
// Shared constants, codes, control structs and helpers for the weighted index sampler.
`timescale 1ns / 1ps
package wis_pkg;

  // Table depth and derived index widths
  localparam int MaxEntries = 256;
  localparam int IdxW       = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int CntW       = $clog2(MaxEntries + 1);

  // Fixed field widths
  localparam int OpW     = 2;
  localparam int WeightW = 17;
  localparam int RandW   = 16;
  localparam int TotalW  = 24;
  localparam int StatW   = 2;
  localparam int OutCntW = 9;

  // Stream bus widths, padded to whole bytes
  localparam int InDataW  = ((WeightW + RandW + 7) / 8) * 8;
  localparam int OutDataW = ((OutCntW + OutCntW + 7) / 8) * 8;

  localparam logic [TotalW-1:0] TotalMax = {TotalW{1'b1}};

  // Operation codes
  localparam logic [OpW-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OpW-1:0] OP_LOAD   = 2'd1;
  localparam logic [OpW-1:0] OP_SAMPLE = 2'd2;

  // Result status codes
  localparam logic [StatW-1:0] ST_OK   = 2'd0;
  localparam logic [StatW-1:0] ST_MISS = 2'd1;
  localparam logic [StatW-1:0] ST_FULL = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic latch_in;   // capture the input transaction
    logic exec;       // apply clear/load, decide sample path
    logic probe_rd;   // read the table at the search midpoint
    logic probe_cmp;  // narrow the search window
    logic finish;     // record the hit index
    logic load_out;   // move the result into the output register
  } wis_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic go_search;  // sample item needs a search
    logic lo_eq_hi;   // search window closed
  } wis_sts_t;

  // Count-width value to the 9-bit output field (masked or zero-extended)
  function automatic logic [OutCntW-1:0] to_out_cnt(input logic [CntW-1:0] v);
    logic [CntW+OutCntW-1:0] wide;
    wide = (CntW + OutCntW)'(v);
    return wide[OutCntW-1:0];
  endfunction

endpackage

>>> design/wis_dp.sv
// Datapath: cumulative table memory, running total, search window and result registers.
`timescale 1ns / 1ps
module wis_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  wis_pkg::wis_cmd_t              cmd,
  output wis_pkg::wis_sts_t              sts,
  input  logic [wis_pkg::OpW-1:0]        in_op,
  input  logic [wis_pkg::WeightW-1:0]    in_weight,
  input  logic [wis_pkg::RandW-1:0]      in_rand,
  output logic [wis_pkg::StatW-1:0]      out_status,
  output logic [wis_pkg::OutCntW-1:0]    out_chosen,
  output logic [wis_pkg::OutCntW-1:0]    out_count
);

  // Cumulative table
  logic [wis_pkg::TotalW-1:0] mem [wis_pkg::MaxEntries];

  // Control state
  logic [wis_pkg::CntW-1:0]   count_r, count_nxt;
  logic [wis_pkg::TotalW-1:0] total_r, total_nxt;

  // Captured transaction
  logic [wis_pkg::OpW-1:0]     op_r;
  logic [wis_pkg::WeightW-1:0] weight_r;
  logic [wis_pkg::RandW-1:0]   rand_r;

  // Search window and probe data
  logic [wis_pkg::IdxW-1:0]   lo_r, hi_r, mid_r, mid;
  logic [wis_pkg::TotalW-1:0] rd_data_r;

  // Result being built and output register
  logic [wis_pkg::StatW-1:0]   res_status_r;
  logic [wis_pkg::CntW-1:0]    res_chosen_r;
  logic [wis_pkg::StatW-1:0]   out_status_r;
  logic [wis_pkg::OutCntW-1:0] out_chosen_r, out_count_r;

  logic [wis_pkg::TotalW:0]   sum_wide;
  logic [wis_pkg::TotalW-1:0] sum_sat;
  logic [wis_pkg::TotalW-1:0] rand_ext;
  logic                       full;
  logic                       do_write;
  logic [wis_pkg::CntW-1:0]   last_idx;
  logic [wis_pkg::CntW-1:0]   lo_plus1;

  // Load arithmetic with saturation
  assign sum_wide = {1'b0, total_r} + (wis_pkg::TotalW + 1)'(weight_r);
  assign sum_sat  = sum_wide[wis_pkg::TotalW] ? wis_pkg::TotalMax
                                               : sum_wide[wis_pkg::TotalW-1:0];
  assign full     = (count_r == wis_pkg::CntW'(wis_pkg::MaxEntries));
  assign do_write = cmd.exec && (op_r == wis_pkg::OP_LOAD) && !full;
  assign rand_ext = wis_pkg::TotalW'(rand_r);
  assign last_idx = count_r - wis_pkg::CntW'(1);
  assign lo_plus1 = wis_pkg::CntW'(lo_r) + wis_pkg::CntW'(1);

  // Midpoint of the window
  assign mid = lo_r + ((hi_r - lo_r) >> 1);

  // Status to controller
  assign sts.go_search = (op_r == wis_pkg::OP_SAMPLE) && (count_r != '0) && (rand_ext < total_r);
  assign sts.lo_eq_hi  = (lo_r == hi_r);

  // Count and total
  always_comb begin
    count_nxt = count_r;
    total_nxt = total_r;
    if (cmd.exec) begin
      if (op_r == wis_pkg::OP_CLEAR) begin
        count_nxt = '0;
        total_nxt = '0;
      end else if (do_write) begin
        count_nxt = count_r + wis_pkg::CntW'(1);
        total_nxt = sum_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      total_r <= '0;
    end else begin
      count_r <= count_nxt;
      total_r <= total_nxt;
    end
  end

  // Table write and registered probe read
  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[count_r[wis_pkg::IdxW-1:0]] <= sum_sat;
    end
    if (cmd.probe_rd) begin
      rd_data_r <= mem[mid];
    end
  end

  // Input capture, search window and result build
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_r     <= in_op;
      weight_r <= in_weight;
      rand_r   <= in_rand;
    end
    if (cmd.exec) begin
      res_chosen_r <= '0;
      lo_r         <= '0;
      hi_r         <= last_idx[wis_pkg::IdxW-1:0];
      unique case (op_r)
        wis_pkg::OP_LOAD:   res_status_r <= full ? wis_pkg::ST_FULL : wis_pkg::ST_OK;
        wis_pkg::OP_SAMPLE: res_status_r <= sts.go_search ? wis_pkg::ST_OK : wis_pkg::ST_MISS;
        default:            res_status_r <= wis_pkg::ST_OK;
      endcase
    end
    if (cmd.probe_rd) begin
      mid_r <= mid;
    end
    if (cmd.probe_cmp) begin
      if (rd_data_r > rand_ext) begin
        hi_r <= mid_r;
      end else begin
        lo_r <= mid_r + wis_pkg::IdxW'(1);
      end
    end
    if (cmd.finish) begin
      res_chosen_r <= lo_plus1;
    end
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_chosen_r <= wis_pkg::to_out_cnt(res_chosen_r);
      out_count_r  <= wis_pkg::to_out_cnt(count_r);
    end
  end

  assign out_status = out_status_r;
  assign out_chosen = out_chosen_r;
  assign out_count  = out_count_r;

endmodule

>>> design/wis_ctrl.sv
// Controller: sequences accept, execute, binary-search probes and result hand-off.
`timescale 1ns / 1ps
module wis_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  wis_pkg::wis_sts_t sts,
  output wis_pkg::wis_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_PROBE,
    S_CMP,
    S_DONE
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_free;

  // Output register can take a new result
  assign out_free = !out_valid_r || out_ready;

  // Commands decoded from state
  always_comb begin
    cmd           = '0;
    cmd.latch_in  = (state_r == S_IDLE) && in_valid;
    cmd.exec      = (state_r == S_EXEC);
    cmd.probe_rd  = (state_r == S_PROBE) && !sts.lo_eq_hi;
    cmd.finish    = (state_r == S_PROBE) && sts.lo_eq_hi;
    cmd.probe_cmp = (state_r == S_CMP);
    cmd.load_out  = (state_r == S_DONE) && out_free;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // State and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) state_r <= S_EXEC;
        end
        S_EXEC: begin
          state_r <= sts.go_search ? S_PROBE : S_DONE;
        end
        S_PROBE: begin
          state_r <= sts.lo_eq_hi ? S_DONE : S_CMP;
        end
        S_CMP: begin
          state_r <= S_PROBE;
        end
        S_DONE: begin
          if (out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

>>> design/weighted_index_sampler.sv
// Top level of the weighted index sampler: stream ports, controller and datapath.
`timescale 1ns / 1ps
// The block holds up to 256 cumulative weights and draws one index per sample
// transaction by binary search over a single-port table memory. Every input
// transaction gives exactly one result transaction. Clear, load and a sample
// that misses go from acceptance through S_EXEC to S_DONE; a sample hit runs
// the search loop between those, which for each probe does a registered
// memory read in S_PROBE and the compare in S_CMP. S_DONE waits until the
// output register is free. One transaction is in work at a time; a finished
// result waits in the output register while the next transaction is taken.
module weighted_index_sampler (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [wis_pkg::InDataW-1:0]      in_tdata,   // weight[16:0], random_value[32:17]
  input  logic [wis_pkg::OpW-1:0]          in_tuser,   // operation[1:0]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [wis_pkg::OutDataW-1:0]     out_tdata,  // chosen_index[8:0], entry_count[17:9]
  output logic [wis_pkg::StatW-1:0]        out_tuser   // status[1:0]
);

  wis_pkg::wis_cmd_t cmd;
  wis_pkg::wis_sts_t sts;

  logic [wis_pkg::OutCntW-1:0] chosen;
  logic [wis_pkg::OutCntW-1:0] count;

  wis_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  wis_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_op      (in_tuser),
    .in_weight  (in_tdata[wis_pkg::WeightW-1:0]),
    .in_rand    (in_tdata[wis_pkg::WeightW +: wis_pkg::RandW]),
    .out_status (out_tuser),
    .out_chosen (chosen),
    .out_count  (count)
  );

  // Pack result fields, zero padded
  assign out_tdata = wis_pkg::OutDataW'({count, chosen});

endmodule
